@@ rtl/irpd_pkg.sv @@
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int TICK_WIDTH_DEF = 24;
    localparam int REG_WIDTH      = 24;
    localparam int FRAME_BYTES    = 4;
    localparam int FRAME_BITS     = FRAME_BYTES * 8;
    localparam int BIT_IDX_WIDTH  = $clog2(FRAME_BITS);
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [BIT_IDX_WIDTH-1:0] LAST_BIT = BIT_IDX_WIDTH'(FRAME_BITS - 1);

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PREAMBLE_MIN   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PREAMBLE_MAX   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_MIN      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MARK_MAX       = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPACE_MAX      = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_BIT      = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MSB_FIRST      = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LINE_INVERTED  = 3'd7;

    // reset values of the registers
    localparam logic [REG_WIDTH-1:0] PREAMBLE_MIN_RST = 24'd4000;
    localparam logic [REG_WIDTH-1:0] PREAMBLE_MAX_RST = 24'd5000;
    localparam logic [REG_WIDTH-1:0] PULSE_MIN_RST    = 24'd400;
    localparam logic [REG_WIDTH-1:0] MARK_MAX_RST     = 24'd800;
    localparam logic [REG_WIDTH-1:0] SPACE_MAX_RST    = 24'd2400;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PREAMBLE = 2'd1,
        ST_MARK     = 2'd2,
        ST_SPACE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0] preamble_min;
        logic [REG_WIDTH-1:0] preamble_max;
        logic [REG_WIDTH-1:0] pulse_min;
        logic [REG_WIDTH-1:0] mark_max;
        logic [REG_WIDTH-1:0] space_max;
        logic                 short_bit_value;
        logic                 msb_first;
        logic                 line_inverted;
    } cfg_t;

    typedef struct packed {
        status_t                  status;
        logic [BIT_IDX_WIDTH-1:0] bit_position;
        logic [7:0]               address;
        logic [7:0]               address_repeat;
        logic [7:0]               command;
        logic [7:0]               command_check;
        logic                     address_mismatch;
        logic                     command_mismatch;
    } result_t;

endpackage

@@ rtl/irpd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Configuration register bank, written one register per word.
// ----------------------------------------------------------------------------
module irpd_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irpd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [irpd_pkg::REG_WIDTH-1:0]      cfg_data,
    output irpd_pkg::cfg_t                      cfg
);

    irpd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_min    <= irpd_pkg::PREAMBLE_MIN_RST;
            cfg_reg.preamble_max    <= irpd_pkg::PREAMBLE_MAX_RST;
            cfg_reg.pulse_min       <= irpd_pkg::PULSE_MIN_RST;
            cfg_reg.mark_max        <= irpd_pkg::MARK_MAX_RST;
            cfg_reg.space_max       <= irpd_pkg::SPACE_MAX_RST;
            cfg_reg.short_bit_value <= 1'b0;
            cfg_reg.msb_first       <= 1'b0;
            cfg_reg.line_inverted   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                irpd_pkg::CFG_PREAMBLE_MIN:  cfg_reg.preamble_min    <= cfg_data;
                irpd_pkg::CFG_PREAMBLE_MAX:  cfg_reg.preamble_max    <= cfg_data;
                irpd_pkg::CFG_PULSE_MIN:     cfg_reg.pulse_min       <= cfg_data;
                irpd_pkg::CFG_MARK_MAX:      cfg_reg.mark_max        <= cfg_data;
                irpd_pkg::CFG_SPACE_MAX:     cfg_reg.space_max       <= cfg_data;
                irpd_pkg::CFG_SHORT_BIT:     cfg_reg.short_bit_value <= cfg_data[0];
                irpd_pkg::CFG_MSB_FIRST:     cfg_reg.msb_first       <= cfg_data[0];
                irpd_pkg::CFG_LINE_INVERTED: cfg_reg.line_inverted   <= cfg_data[0];
                default:                     cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

@@ rtl/irpd_decoder.sv @@
// ----------------------------------------------------------------------------
// irpd_decoder
// Input register and frame state machine; one phase decoded per cycle while res_space is high.
// ----------------------------------------------------------------------------
module irpd_decoder
#(
    parameter int TICK_WIDTH = irpd_pkg::TICK_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TICK_WIDTH-1:0] in_ticks,
    input  logic                  in_level,
    input  irpd_pkg::cfg_t        cfg,
    input  logic                  res_space,
    output logic                  res_valid,
    output irpd_pkg::result_t     res
);

    localparam int CW = ((TICK_WIDTH > irpd_pkg::REG_WIDTH) ? TICK_WIDTH
                                                            : irpd_pkg::REG_WIDTH) + 1;
    localparam int BW = irpd_pkg::BIT_IDX_WIDTH;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_PRE2  = 3'd1,
        PH_MARK  = 3'd2,
        PH_SPACE = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic [BW-1:0]                        bit_count_reg, bit_count_next;
    logic [irpd_pkg::FRAME_BITS-1:0]      frame_reg, frame_next, frame_set;
    logic [TICK_WIDTH-1:0]                mark_reg, mark_next;
    logic                                 in_valid_reg;
    logic [TICK_WIDTH-1:0]                ticks_reg;
    logic                                 level_reg;
    logic                                 fire;
    logic                                 win_pre, win_mark, win_space, short_space;
    logic                                 bit_val;
    logic [BW-1:0]                        bit_pos;
    logic [7:0]                           b0, b1, b2, b3c;

    function automatic logic in_window(input logic [CW-1:0] d,
                                       input logic [CW-1:0] lo,
                                       input logic [CW-1:0] hi);
        in_window = (d > lo) && (d <= hi);
    endfunction

    assign fire     = in_valid_reg && res_space;
    assign in_ready = !in_valid_reg || res_space;

    assign win_pre   = in_window(CW'(ticks_reg), CW'(cfg.preamble_min), CW'(cfg.preamble_max));
    assign win_mark  = in_window(CW'(ticks_reg), CW'(cfg.pulse_min), CW'(cfg.mark_max));
    assign win_space = in_window(CW'(ticks_reg), CW'(cfg.pulse_min), CW'(cfg.space_max));

    // short space: no longer than twice the preceding mark
    assign short_space = {1'b0, ticks_reg} <= {mark_reg, 1'b0};
    assign bit_val     = short_space ? cfg.short_bit_value : !cfg.short_bit_value;
    assign bit_pos     = {bit_count_reg[BW-1:3],
                          cfg.msb_first ? ~bit_count_reg[2:0] : bit_count_reg[2:0]};

    always_comb
    begin
        frame_set          = frame_reg;
        frame_set[bit_pos] = frame_reg[bit_pos] | bit_val;
    end

    assign b0  = frame_set[7:0];
    assign b1  = frame_set[15:8];
    assign b2  = frame_set[23:16];
    assign b3c = frame_set[31:24] ^ irpd_pkg::BYTE_ONES;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        frame_next     = frame_reg;
        mark_next      = mark_reg;
        res_valid      = 1'b0;
        res            = '0;
        if (fire)
        begin
            unique case (phase_reg)
                PH_PRE2:
                begin
                    if (!win_pre)
                    begin
                        phase_next     = PH_HUNT;
                        bit_count_next = '0;
                        frame_next     = '0;
                        res_valid      = 1'b1;
                        res.status     = irpd_pkg::ST_PREAMBLE;
                    end
                    else
                    begin
                        phase_next     = PH_MARK;
                        bit_count_next = '0;
                        frame_next     = '0;
                    end
                end
                PH_MARK:
                begin
                    if (!win_mark)
                    begin
                        phase_next       = PH_HUNT;
                        bit_count_next   = '0;
                        frame_next       = '0;
                        res_valid        = 1'b1;
                        res.status       = irpd_pkg::ST_MARK;
                        res.bit_position = bit_count_reg;
                    end
                    else
                    begin
                        mark_next  = ticks_reg;
                        phase_next = PH_SPACE;
                    end
                end
                PH_SPACE:
                begin
                    if (!win_space)
                    begin
                        phase_next       = PH_HUNT;
                        bit_count_next   = '0;
                        frame_next       = '0;
                        res_valid        = 1'b1;
                        res.status       = irpd_pkg::ST_SPACE;
                        res.bit_position = bit_count_reg;
                    end
                    else if (bit_count_reg != irpd_pkg::LAST_BIT)
                    begin
                        frame_next     = frame_set;
                        bit_count_next = bit_count_reg + 1'b1;
                        phase_next     = PH_MARK;
                    end
                    else
                    begin
                        // last bit: report the frame, then skip the stop mark
                        phase_next           = PH_STOP;
                        bit_count_next       = '0;
                        frame_next           = '0;
                        res_valid            = 1'b1;
                        res.status           = irpd_pkg::ST_OK;
                        res.address          = b0;
                        res.address_repeat   = b1;
                        res.command          = b2;
                        res.command_check    = b3c;
                        res.address_mismatch = (b1 != b0);
                        res.command_mismatch = (b3c != b2);
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (level_reg != cfg.line_inverted)
                    begin
                        if (!win_pre)
                        begin
                            bit_count_next = '0;
                            frame_next     = '0;
                            res_valid      = 1'b1;
                            res.status     = irpd_pkg::ST_PREAMBLE;
                        end
                        else
                        begin
                            phase_next = PH_PRE2;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            bit_count_reg <= '0;
            frame_reg     <= '0;
            mark_reg      <= '0;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            frame_reg     <= frame_next;
            mark_reg      <= mark_next;
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ticks_reg <= in_ticks;
            level_reg <= in_level;
        end
    end

endmodule

@@ rtl/irpd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// irpd_out_fifo
// Two-word result buffer that parts the decoder from the output handshake.
// ----------------------------------------------------------------------------
module irpd_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  irpd_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output irpd_pkg::result_t out_data
);

    irpd_pkg::result_t mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // a full buffer still takes a word when the head leaves in the same cycle
    assign space     = (count_reg != 2'd2) || out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/ir_pulse_distance_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_core
// Decodes measured IR line phases into 32-bit address/command frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one line phase per word: its length in ticks (saturated by the
//   edge timer) in s_tdata and its raw level in s_tuser. m_* carries one word
//   per finished frame or per first timing error; m_tuser holds the status.
//   cfg_* writes one register per word; write only while the decoder is idle.
// Path: a phase accepted into the input register is decoded from there, and
//   its result, if any, is written to the result buffer and shown on m_* from it.
// Throughput: one phase per cycle while the result buffer has room; the input
//   register, one pass of compare/bit-insert logic and a two-word buffer set it.
// Reset: control and config registers return to their defaults, the decoder
//   hunts for a preamble and both buffers empty. No clearing pass is needed.
// Stall: while m_tready is low the result buffer fills; once it holds two
//   words, hold the next phase in the input register and drop s_tready until
//   the receiver takes a word, whether or not that phase gives a result.
//   One more phase is taken into an empty input register before s_tready drops.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_core
#(
    parameter int TICK_WIDTH = irpd_pkg::TICK_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // phase_ticks [TICK_WIDTH-1:0], zero padding above
    input  logic [((TICK_WIDTH + 7) / 8) * 8-1:0]  s_tdata,
    // phase_level [0]
    input  logic                                   s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // bit_position [4:0], address [12:5], address_repeat [20:13],
    // command [28:21], command_check [36:29], address_mismatch [37],
    // command_mismatch [38], zero [39]
    output logic [irpd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // status [1:0]
    output logic [1:0]                             m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [irpd_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [irpd_pkg::REG_WIDTH-1:0]         cfg_data
);

    irpd_pkg::cfg_t    cfg;
    irpd_pkg::result_t res;
    irpd_pkg::result_t head;
    logic              res_valid;
    logic              res_space;

    // register bank
    irpd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and frame state machine
    irpd_decoder #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ticks  (s_tdata[TICK_WIDTH-1:0]),
        .in_level  (s_tuser),
        .cfg       (cfg),
        .res_space (res_space),
        .res_valid (res_valid),
        .res       (res)
    );

    // result buffer: keeps the decoder running while the receiver stalls, until it fills
    irpd_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (res_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // pack the result word, lowest field first
    assign m_tuser = head.status;
    assign m_tdata = {1'b0,
                      head.command_mismatch,
                      head.address_mismatch,
                      head.command_check,
                      head.command,
                      head.address_repeat,
                      head.address,
                      head.bit_position};

`ifndef SYNTHESIS
    // the decoder only pushes when the buffer has room
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_space)
        else $error("result pushed into a full buffer");

    // a good frame never reports a failing bit index
    a_ok_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == irpd_pkg::ST_OK)) |-> (m_tdata[4:0] == 5'd0))
        else $error("frame result carries a bit index");

    // a timing error carries no frame bytes or check flags
    a_error_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != irpd_pkg::ST_OK)) |-> (m_tdata[39:5] == 35'd0))
        else $error("error result carries frame data");

    // the input stalls only while the buffer's head waits on a low m_tready
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready) |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output side is free");
`endif

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IR pulse-distance frame decoder. Line phases go
// in through the slave stream and a phase-by-phase decoder model in a small
// scoreboard class predicts every result word. Each word taken from the
// master stream is checked field by field against the oldest prediction.
// Register settings run from the reset values to fully open and fully closed
// timing windows. Both stream sides idle and stall at random, and one
// long receiver hold-off forces the decoder to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    localparam int          TICK_W        = TICK_WIDTH_DEF;
    localparam int unsigned TICK_MAX      = (1 << TICK_W) - 1;
    // margin once every expected word has come back, so the pipe can empty
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          RX_HOLD_CYCLES = 120;

    // where the decoder model stands inside a frame
    typedef enum logic [2:0] {
        DP_HUNT  = 3'd0,
        DP_PRE2  = 3'd1,
        DP_MARK  = 3'd2,
        DP_SPACE = 3'd3,
        DP_STOP  = 3'd4
    } dec_stage_t;

    // ------------------------------------------------------------------------
    // Decoder model and store of expected words
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        cfg_t              cfg;
        dec_stage_t        stage;
        logic [4:0]        bit_idx;
        logic [31:0]       frame_word;
        logic [TICK_W-1:0] mark_len;
        result_t           pending[$];
        int unsigned       n_used, n_words, n_frames, n_timing, n_bad, n_shown;

        function new();
            cfg.preamble_min    = PREAMBLE_MIN_RST;
            cfg.preamble_max    = PREAMBLE_MAX_RST;
            cfg.pulse_min       = PULSE_MIN_RST;
            cfg.mark_max        = MARK_MAX_RST;
            cfg.space_max       = SPACE_MAX_RST;
            cfg.short_bit_value = 1'b0;
            cfg.msb_first       = 1'b0;
            cfg.line_inverted   = 1'b0;
            stage      = DP_HUNT;
            bit_idx    = '0;
            frame_word = '0;
            mark_len   = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] value);
            case (idx)
                CFG_PREAMBLE_MIN:  cfg.preamble_min    = value;
                CFG_PREAMBLE_MAX:  cfg.preamble_max    = value;
                CFG_PULSE_MIN:     cfg.pulse_min       = value;
                CFG_MARK_MAX:      cfg.mark_max        = value;
                CFG_SPACE_MAX:     cfg.space_max       = value;
                CFG_SHORT_BIT:     cfg.short_bit_value = value[0];
                CFG_MSB_FIRST:     cfg.msb_first       = value[0];
                CFG_LINE_INVERTED: cfg.line_inverted   = value[0];
                default: ;
            endcase
        endfunction

        function bit in_win(logic [TICK_W-1:0] d, logic [REG_WIDTH-1:0] lo,
                            logic [REG_WIDTH-1:0] hi);
            return d > lo && d <= hi;
        endfunction

        // first timing error: report it and go back to hunting
        function void timing_fail(status_t st, logic [4:0] at);
            result_t r;
            r = '0;
            r.status = st;
            r.bit_position = at;
            pending.push_back(r);
            n_timing++;
            stage = DP_HUNT;
            bit_idx = '0;
            frame_word = '0;
        endfunction

        // advance the model by one accepted phase and queue any word it causes
        function void note_phase(logic [TICK_W-1:0] ticks, logic level);
            result_t    r;
            logic       bitv;
            logic [4:0] pos;
            bit         ignored;
            ignored = !(stage inside {DP_PRE2, DP_MARK, DP_SPACE, DP_STOP})
                      && level == cfg.line_inverted;
            if (!ignored)
                n_used++;
            case (stage)
                DP_PRE2:
                    if (!in_win(ticks, cfg.preamble_min, cfg.preamble_max))
                        timing_fail(ST_PREAMBLE, '0);
                    else
                    begin
                        stage = DP_MARK;
                        bit_idx = '0;
                        frame_word = '0;
                    end
                DP_MARK:
                    if (!in_win(ticks, cfg.pulse_min, cfg.mark_max))
                        timing_fail(ST_MARK, bit_idx);
                    else
                    begin
                        mark_len = ticks;
                        stage = DP_SPACE;
                    end
                DP_SPACE:
                    if (!in_win(ticks, cfg.pulse_min, cfg.space_max))
                        timing_fail(ST_SPACE, bit_idx);
                    else
                    begin
                        // short space: no longer than twice its mark
                        bitv = ({1'b0, ticks} <= {mark_len, 1'b0}) ? cfg.short_bit_value
                                                                    : ~cfg.short_bit_value;
                        pos = cfg.msb_first ? (bit_idx ^ 5'd7) : bit_idx;
                        if (bitv)
                            frame_word[pos] = 1'b1;
                        if (bit_idx != LAST_BIT)
                        begin
                            bit_idx = bit_idx + 5'd1;
                            stage = DP_MARK;
                        end
                        else
                        begin
                            r = '0;
                            r.status           = ST_OK;
                            r.address          = frame_word[7:0];
                            r.address_repeat   = frame_word[15:8];
                            r.command          = frame_word[23:16];
                            r.command_check    = frame_word[31:24] ^ BYTE_ONES;
                            r.address_mismatch = r.address_repeat != r.address;
                            r.command_mismatch = r.command_check != r.command;
                            pending.push_back(r);
                            n_frames++;
                            stage = DP_STOP;
                            bit_idx = '0;
                            frame_word = '0;
                        end
                    end
                DP_STOP:
                    stage = DP_HUNT;    // stop mark is swallowed whatever it is
                default:
                begin
                    stage = DP_HUNT;
                    if (level != cfg.line_inverted)
                    begin
                        if (!in_win(ticks, cfg.preamble_min, cfg.preamble_max))
                            timing_fail(ST_PREAMBLE, '0);
                        else
                            stage = DP_PRE2;
                    end
                end
            endcase
        endfunction

        function string show(result_t r);
            return $sformatf("st=%0d pos=%0d a=%02h ar=%02h c=%02h cc=%02h am=%0b cm=%0b",
                             r.status, r.bit_position, r.address, r.address_repeat,
                             r.command, r.command_check, r.address_mismatch,
                             r.command_mismatch);
        endfunction

        function void report(string what, result_t want, result_t got);
            n_bad++;
            if (n_shown < 10)
            begin
                n_shown++;
                $display("%0t %s: expected %s, got %s", $time, what, show(want), show(got));
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            n_words++;
            if (pending.size() == 0)
            begin
                want = '0;
                report("unexpected word", want, got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status || got.bit_position != want.bit_position ||
                got.address != want.address || got.address_repeat != want.address_repeat ||
                got.command != want.command || got.command_check != want.command_check ||
                got.address_mismatch != want.address_mismatch ||
                got.command_mismatch != want.command_mismatch)
                report("word mismatch", want, got);
        endfunction

        function void close_out();
            if (pending.size() != 0)
            begin
                n_bad += pending.size();
                $display("%0d expected words never arrived", pending.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic [TICK_W-1:0]        s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [1:0]               m_tuser;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = CFG_PREAMBLE_MIN;
    logic [REG_WIDTH-1:0]     cfg_data  = '0;

    always #5ns clk = ~clk;

    ir_pulse_distance_frame_decoder_core #(
        .TICK_WIDTH (TICK_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),     // phase_ticks [23:0]
        .s_tuser   (s_tuser),     // phase_level [0]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),     // bit_position, address, address_repeat, command,
                                  // command_check, address_mismatch, command_mismatch
        .m_tuser   (m_tuser),     // status [1:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_scoreboard sb;

    // switches shared by the sender and the receiver processes
    bit tx_gap_en   = 1'b1;
    bit rx_stall_en = 1'b1;
    bit rx_hold_req = 1'b0;
    int unsigned n_settings = 0;

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // any duration: full range, the two extremes, or near the usual timings
    function automatic int unsigned rand_ticks();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, TICK_MAX);
        if (r == 5)
            return 0;
        if (r == 6)
            return TICK_MAX;
        return $urandom_range(0, 6000);
    endfunction

    // a duration in (lo, hi], leaning on both edges; anything if that is empty
    function automatic int unsigned pick_inside(int unsigned lo, int unsigned hi);
        int unsigned r;
        if (hi <= lo)
            return rand_ticks();
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo + 1;
        if (r == 1)
            return hi;
        return $urandom_range(lo + 1, hi);
    endfunction

    // a duration outside (lo, hi]; zero is always outside, so this never fails
    function automatic int unsigned pick_outside(int unsigned lo, int unsigned hi);
        if (hi < TICK_MAX && $urandom_range(0, 1) == 1)
            return ($urandom_range(0, 3) == 0) ? hi + 1 : $urandom_range(hi + 1, TICK_MAX);
        return ($urandom_range(0, 3) == 0) ? lo : $urandom_range(0, lo);
    endfunction

    function automatic cfg_t make_cfg(int unsigned pmin, int unsigned pmax, int unsigned pulse,
                                      int unsigned mmax, int unsigned smax,
                                      bit short_val, bit msb, bit inv);
        cfg_t c;
        c.preamble_min    = REG_WIDTH'(pmin);
        c.preamble_max    = REG_WIDTH'(pmax);
        c.pulse_min       = REG_WIDTH'(pulse);
        c.mark_max        = REG_WIDTH'(mmax);
        c.space_max       = REG_WIDTH'(smax);
        c.short_bit_value = short_val;
        c.msb_first       = msb;
        c.line_inverted   = inv;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // offer one phase word and hold it until taken; tvalid stays high after
    task automatic send_phase(input int unsigned ticks, input logic level);
        int unsigned gap;
        gap = tx_gap_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= TICK_W'(ticks);
        s_tuser  <= level;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_phase(TICK_W'(ticks), level);
    endtask

    // drop tvalid, wait for every expected word, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register word; cfg_valid is left high for a following write
    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [REG_WIDTH-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic program_cfg(input cfg_t c);
        cfg_write(CFG_PREAMBLE_MIN, c.preamble_min);
        cfg_write(CFG_PREAMBLE_MAX, c.preamble_max);
        cfg_write(CFG_PULSE_MIN, c.pulse_min);
        cfg_write(CFG_MARK_MAX, c.mark_max);
        cfg_write(CFG_SPACE_MAX, c.space_max);
        cfg_write(CFG_SHORT_BIT, {{(REG_WIDTH-1){1'b0}}, c.short_bit_value});
        cfg_write(CFG_MSB_FIRST, {{(REG_WIDTH-1){1'b0}}, c.msb_first});
        cfg_write(CFG_LINE_INVERTED, {{(REG_WIDTH-1){1'b0}}, c.line_inverted});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // bring the decoder back to hunting with one timing error (or the stop mark)
    task automatic flush_frame();
        logic act;
        while (sb.stage != DP_HUNT)
        begin
            act = ~sb.cfg.line_inverted;
            case (sb.stage)
                DP_PRE2:  send_phase(pick_outside(32'(sb.cfg.preamble_min),
                                                  32'(sb.cfg.preamble_max)), ~act);
                DP_MARK:  send_phase(pick_outside(32'(sb.cfg.pulse_min),
                                                  32'(sb.cfg.mark_max)), act);
                DP_SPACE: send_phase(pick_outside(32'(sb.cfg.pulse_min),
                                                  32'(sb.cfg.space_max)), ~act);
                default:  send_phase(rand_ticks(), act);
            endcase
        end
    endtask

    // One frame built to the current windows: two preamble phases, 32 mark/space
    // pairs carrying a chosen word, then a stop mark. A broken frame puts one
    // phase outside its window and stops there.
    task automatic send_frame(input bit broken);
        logic        act, lvl, bitv;
        logic [31:0] word;
        logic [4:0]  pos;
        int unsigned bad_at, n, k, lo, hi, t, mark, twice, edge_val;
        act    = ~sb.cfg.line_inverted;
        bad_at = broken ? $urandom_range(0, 65) : 66;
        mark   = 0;
        word[7:0]   = 8'($urandom);
        word[15:8]  = ($urandom_range(0, 3) != 0) ? word[7:0] : 8'($urandom);
        word[23:16] = 8'($urandom);
        word[31:24] = ($urandom_range(0, 3) != 0) ? ~word[23:16] : 8'($urandom);
        // an idle-level lead-in is ignored while hunting
        if ($urandom_range(0, 3) == 0)
            send_phase(rand_ticks(), ~act);
        for (n = 0; n < 66; n++)
        begin
            lvl = (n % 2 == 0) ? act : ~act;
            if (n < 2)
            begin
                lo = 32'(sb.cfg.preamble_min);
                hi = 32'(sb.cfg.preamble_max);
            end
            else
            begin
                lo = 32'(sb.cfg.pulse_min);
                hi = (n % 2 == 0) ? 32'(sb.cfg.mark_max) : 32'(sb.cfg.space_max);
            end
            if (n == bad_at)
                t = pick_outside(lo, hi);
            else if (n < 2 || n % 2 == 0)
                t = pick_inside(lo, hi);
            else
            begin
                // choose a short or long space so the wanted bit comes out
                k     = (n - 2) / 2;
                pos   = sb.cfg.msb_first ? (5'(k) ^ 5'd7) : 5'(k);
                bitv  = word[pos];
                twice = 2 * mark;
                if (bitv == sb.cfg.short_bit_value)
                begin
                    edge_val = (hi < twice) ? hi : twice;
                    t = (edge_val > lo) ? pick_inside(lo, edge_val) : pick_inside(lo, hi);
                end
                else
                begin
                    edge_val = (lo > twice) ? lo : twice;
                    t = (hi > edge_val) ? pick_inside(edge_val, hi) : pick_inside(lo, hi);
                end
            end
            if (n >= 2 && n % 2 == 0)
                mark = t;
            send_phase(t, lvl);
            if (n == bad_at)
                return;
        end
        // stop mark: swallowed whatever its timing or level
        send_phase(rand_ticks(), 1'($urandom_range(0, 1)));
    endtask

    // well-formed frames with random content (the largest share), broken frames
    // and bursts of noise; gaps and stalls switch on and off per sequence
    task automatic run_mix(input int unsigned budget);
        int unsigned stop_at, n, burst;
        stop_at = sb.n_used + budget;
        while (sb.n_used < stop_at)
        begin
            tx_gap_en   = $urandom_range(0, 3) != 0;
            rx_stall_en = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_frame(1'b0);
                4, 5, 6:    send_frame(1'b1);
                default:
                begin
                    burst = $urandom_range(1, 8);
                    for (n = 0; n < burst; n++)
                        send_phase(rand_ticks(), 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    task automatic new_setting(input cfg_t c, input int unsigned budget);
        flush_frame();
        drain();
        program_cfg(c);
        run_mix(budget);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                // hold off long enough for the result buffer to fill
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_stall_en && $urandom_range(0, 99) < 25)
            begin
                stall = 1 + pick_gap();
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: sample the master stream at the edge and check the word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status           = status_t'(m_tuser);
            got.bit_position     = m_tdata[4:0];
            got.address          = m_tdata[12:5];
            got.address_repeat   = m_tdata[20:13];
            got.command          = m_tdata[28:21];
            got.command_check    = m_tdata[36:29];
            got.address_mismatch = m_tdata[37];
            got.command_mismatch = m_tdata[38];
            sb.check_word(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned n, pmin, pulse, mmax;
        cfg_t        c;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (idle low, 4000..5000, 400..800..2400)
        send_phase(4500, 1'b0);           // idle-level phase while hunting: ignored
        send_phase(0, 1'b0);              // zero-length idle phase: ignored
        send_phase(0, 1'b1);              // zero-length preamble: preamble error
        send_phase(4000, 1'b1);           // exactly at the lower bound: too short
        send_phase(5001, 1'b1);           // one past the upper bound: too long
        send_phase(TICK_MAX, 1'b1);       // saturated timer value
        send_phase(4001, 1'b1);           // preamble window edges both pass
        send_phase(5000, 1'b0);
        send_phase(400, 1'b1);            // mark at pulse_min: mark error on bit 0
        send_phase(4500, 1'b1);
        send_phase(4500, 1'b0);
        send_phase(800, 1'b1);            // longest legal mark
        send_phase(2401, 1'b0);           // space past space_max: space error on bit 0
        send_phase(4500, 1'b1);
        send_phase(4000, 1'b0);           // second preamble phase too short
        send_phase(4500, 1'b1);
        send_phase(4500, 1'b0);
        send_phase(401, 1'b1);            // shortest legal mark
        send_phase(802, 1'b0);            // exactly twice the mark: short space
        send_phase(600, 1'b1);
        send_phase(1201, 1'b0);           // just over twice the mark: long space
        send_phase(801, 1'b1);            // mark too long: mark error on bit 2
        drain();

        // Overrun: the receiver holds off while bad preambles arrive back to back,
        // with idle phases between, so the decoder must stall its input
        tx_gap_en   = 1'b0;
        rx_hold_req = 1'b1;
        for (n = 0; n < 30; n++)
        begin
            if (n % 5 == 4)
                send_phase(rand_ticks(), 1'b0);
            else
                send_phase(pick_outside(32'(PREAMBLE_MIN_RST), 32'(PREAMBLE_MAX_RST)), 1'b1);
        end
        // pause until every word has come back
        drain();

        // Register settings: usual timings with every flag flipped, then the extremes
        new_setting(make_cfg(4000, 5000, 400, 800, 2400, 1'b1, 1'b1, 1'b1), 130);
        new_setting(make_cfg(0, TICK_MAX, 0, TICK_MAX, TICK_MAX, 1'b0, 1'b0, 1'b1), 70);
        new_setting(make_cfg(0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0), 20);
        new_setting(make_cfg(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX,
                             1'b0, 1'b1, 1'b1), 20);

        // random but workable windows
        pmin  = $urandom_range(500, 6000);
        pulse = $urandom_range(0, 600);
        mmax  = pulse + $urandom_range(1, 800);
        c = make_cfg(pmin, pmin + $urandom_range(1, 2000), pulse, mmax,
                     2 * mmax + $urandom_range(1, 1500), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        new_setting(c, 90);

        // every register at a fully random value
        c = make_cfg($urandom_range(0, TICK_MAX), $urandom_range(0, TICK_MAX),
                     $urandom_range(0, TICK_MAX), $urandom_range(0, TICK_MAX),
                     $urandom_range(0, TICK_MAX), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        new_setting(c, 40);

        // back to the reset values
        new_setting(make_cfg(32'(PREAMBLE_MIN_RST), 32'(PREAMBLE_MAX_RST), 32'(PULSE_MIN_RST),
                             32'(MARK_MAX_RST), 32'(SPACE_MAX_RST), 1'b0, 1'b0, 1'b0), 130);

        drain();
        sb.close_out();
        $display("summary: %0d phases decoded over %0d register settings",
                 sb.n_used, n_settings);
        $display("summary: %0d words checked, %0d whole frames, %0d timing faults, %0d bad",
                 sb.n_words, sb.n_frames, sb.n_timing, sb.n_bad);
        if (sb.n_bad == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: far beyond the slowest correct run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #4ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
